[src/tra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_pkg: shared types and constants of the tanh rational approximation
// Fixed-point widths, polynomial coefficients and the divider side-band type.
// ----------------------------------------------------------------------------
package tra_pkg;

  // port field widths
  localparam int SAMPLE_W = 16;
  localparam int ACT_W    = 16;

  // magnitude of the sample and its square (up to 2^15 and 2^30)
  localparam int MAG_W = 16;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int Q_W   = 31;
  localparam int Q2P_W = 2 * Q_W;
  localparam int Q2_W  = 61;

  // scale of one unit of x^2 in the integer polynomials (2^24)
  localparam int U_SH = 24;

  // Horner intermediates
  localparam int LIMB_W = 32;
  localparam int N2_W   = 64;
  localparam int D2_W   = 67;
  localparam int PN_W   = LIMB_W + Q_W;
  localparam int D2H_W  = D2_W - LIMB_W;
  localparam int PDH_W  = D2H_W + Q_W;
  localparam int N3_W   = 94;
  localparam int N3H_W  = N3_W - 2 * LIMB_W;
  localparam int PA_W   = LIMB_W + MAG_W;
  localparam int PAH_W  = N3H_W + MAG_W;
  localparam int B_W    = 97;

  // dividend 8A + B and divisor 2B
  localparam int A_SH  = 3;
  localparam int NUM_W = 112;
  localparam int DEN_W = B_W + 1;

  // quotient in Q1.14
  localparam int FRAC_W = 14;
  localparam int QUO_W  = FRAC_W + 1;
  localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(1) << FRAC_W;

  // numerator coefficients: x^7 term is one
  localparam int unsigned NC2 = 378;
  localparam int unsigned NC1 = 17325;
  localparam int unsigned NC0 = 135135;
  // denominator coefficients
  localparam int unsigned DC3 = 28;
  localparam int unsigned DC2 = 3150;
  localparam int unsigned DC1 = 62370;
  localparam int unsigned DC0 = 135135;

  // side band that travels with the partial remainder
  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             eov;
  } div_side_t;

endpackage

[src/tra_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_if: stream channels of the tanh rational approximation
// Sample channel in and activation channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tra_in_if;
  import tra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_vector;

  modport source (output valid, output sample, output end_of_vector, input ready);
  modport sink   (input valid, input sample, input end_of_vector, output ready);
endinterface

interface tra_out_if;
  import tra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACT_W-1:0] activation;
  logic                    end_of_vector_out;

  modport source (output valid, output activation, output end_of_vector_out, input ready);
  modport sink   (input valid, input activation, input end_of_vector_out, output ready);
endinterface

[src/tra_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_div_stage: one restoring division step
// Resolves quotient bit K by a compare and subtract of the divisor shifted
// by K, registered under the stage enable.
// ----------------------------------------------------------------------------
module tra_div_stage #(
  parameter int K = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tra_pkg::DEN_W+K:0]  rem_i,
  input  logic [tra_pkg::DEN_W-1:0]  den_i,
  input  tra_pkg::div_side_t         side_i,
  output logic [tra_pkg::NUM_W-1:0]  rem_o,
  output logic [tra_pkg::DEN_W-1:0]  den_o,
  output tra_pkg::div_side_t         side_o
);
  import tra_pkg::*;

  localparam int RIN_W  = DEN_W + K + 1;
  localparam int ROUT_W = DEN_W + K;

  logic [RIN_W:0]      diff;
  logic                ge;
  logic [ROUT_W-1:0]   rem_d, rem_q;
  logic [DEN_W-1:0]    den_q;
  div_side_t           side_d, side_q;

  // trial subtraction, borrow out decides the bit
  always_comb begin
    diff   = {1'b0, rem_i} - {1'b0, RIN_W'(den_i) << K};
    ge     = ~diff[RIN_W];
    rem_d  = ge ? diff[ROUT_W-1:0] : rem_i[ROUT_W-1:0];
    side_d = side_i;
    if (ge) begin
      side_d.quo = side_i.quo | (QUO_W'(1) << K);
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      side_q <= side_d;
    end
  end

  assign rem_o  = NUM_W'(rem_q);
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

[src/tanh_rational_approximation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_rational_approximation: Pade [7/6] tanh on Q3.12 samples
// Evaluates a/b exactly and returns the rounded, clamped Q1.14 quotient.
// ----------------------------------------------------------------------------
// Takes one Q3.12 sample per clock while the output is not stalled and
// returns one Q1.14 activation per sample, in order, with the end-of-vector
// mark carried alongside. The pipeline has seven stages of Horner evaluation
// built from multipliers of at most about 32x32 bits, one saturation check,
// and a restoring divider that resolves one quotient bit per stage, with the
// last bit and the sign folded into the output register. Every stage holds
// its item under back-pressure and empty stages fill up, so a sample is
// accepted whenever the output register is empty or being taken.
module tanh_rational_approximation (
  input logic      clk_i,
  input logic      rst_ni,
  tra_in_if.sink   in_i,
  tra_out_if.source out_o
);
  import tra_pkg::*;

  localparam int DIV_STAGES = FRAC_W - 1;
  localparam int ST_SAT     = 7;
  localparam int ST_OUT     = ST_SAT + DIV_STAGES + 1;
  localparam int NSTG       = ST_OUT + 1;

  // pipeline control
  logic [NSTG-1:0] v_q, v_d, en;

  assign v_d = {v_q[NSTG-2:0], in_i.valid};
  assign en[NSTG-1] = ~v_q[NSTG-1] | out_o.ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en[i] = ~v_q[i] | en[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          v_q[i] <= v_d[i];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // stage 1: magnitude and square
  logic [MAG_W-1:0] s1_mag_d, s1_mag_q;
  logic [SQ_W-1:0]  s1_sq;
  logic [Q_W-1:0]   s1_q_d, s1_q_q;
  logic             s1_neg_q, s1_eov_q;

  always_comb begin
    s1_mag_d = in_i.sample[SAMPLE_W-1] ? MAG_W'(-in_i.sample) : MAG_W'(in_i.sample);
    s1_sq    = SQ_W'(s1_mag_d) * SQ_W'(s1_mag_d);
    s1_q_d   = s1_sq[Q_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_mag_q <= s1_mag_d;
      s1_q_q   <= s1_q_d;
      s1_neg_q <= in_i.sample[SAMPLE_W-1];
      s1_eov_q <= in_i.end_of_vector;
    end
  end

  // stage 2: fourth power
  logic [Q2P_W-1:0] s2_q2p;
  logic [Q2_W-1:0]  s2_q2_q;
  logic [Q_W-1:0]   s2_q_q;
  logic [MAG_W-1:0] s2_mag_q;
  logic             s2_neg_q, s2_eov_q;

  assign s2_q2p = Q2P_W'(s1_q_q) * Q2P_W'(s1_q_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q2_q  <= s2_q2p[Q2_W-1:0];
      s2_q_q   <= s1_q_q;
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s2_eov_q <= s1_eov_q;
    end
  end

  // stage 3: second Horner step of both polynomials
  logic [N2_W-1:0]  s3_n2_d, s3_n2_q;
  logic [D2_W-1:0]  s3_d2_d, s3_d2_q;
  logic [Q_W-1:0]   s3_q_q;
  logic [MAG_W-1:0] s3_mag_q;
  logic             s3_neg_q, s3_eov_q;

  always_comb begin
    s3_n2_d = N2_W'(s2_q2_q)
            + ((N2_W'(s2_q_q) * N2_W'(NC2)) << U_SH)
            + (N2_W'(NC1) << (2 * U_SH));
    s3_d2_d = D2_W'(s2_q2_q) * D2_W'(DC3)
            + ((D2_W'(s2_q_q) * D2_W'(DC2)) << U_SH)
            + (D2_W'(DC1) << (2 * U_SH));
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_n2_q  <= s3_n2_d;
      s3_d2_q  <= s3_d2_d;
      s3_q_q   <= s2_q_q;
      s3_mag_q <= s2_mag_q;
      s3_neg_q <= s2_neg_q;
      s3_eov_q <= s2_eov_q;
    end
  end

  // stage 4: limb products with x^2
  logic [PN_W-1:0]  s4_pn_lo_q, s4_pn_hi_q, s4_pd_lo_q;
  logic [PDH_W-1:0] s4_pd_hi_q;
  logic [MAG_W-1:0] s4_mag_q;
  logic             s4_neg_q, s4_eov_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_pn_lo_q <= PN_W'(s3_n2_q[LIMB_W-1:0]) * PN_W'(s3_q_q);
      s4_pn_hi_q <= PN_W'(s3_n2_q[N2_W-1:LIMB_W]) * PN_W'(s3_q_q);
      s4_pd_lo_q <= PN_W'(s3_d2_q[LIMB_W-1:0]) * PN_W'(s3_q_q);
      s4_pd_hi_q <= PDH_W'(s3_d2_q[D2_W-1:LIMB_W]) * PDH_W'(s3_q_q);
      s4_mag_q   <= s3_mag_q;
      s4_neg_q   <= s3_neg_q;
      s4_eov_q   <= s3_eov_q;
    end
  end

  // stage 5: close the Horner sums
  logic [N3_W-1:0]  s5_n3_d, s5_n3_q;
  logic [B_W-1:0]   s5_b_d, s5_b_q;
  logic [MAG_W-1:0] s5_mag_q;
  logic             s5_neg_q, s5_eov_q;

  always_comb begin
    s5_n3_d = (N3_W'(s4_pn_hi_q) << LIMB_W) + N3_W'(s4_pn_lo_q)
            + (N3_W'(NC0) << (3 * U_SH));
    s5_b_d  = (B_W'(s4_pd_hi_q) << LIMB_W) + B_W'(s4_pd_lo_q)
            + (B_W'(DC0) << (3 * U_SH));
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_n3_q  <= s5_n3_d;
      s5_b_q   <= s5_b_d;
      s5_mag_q <= s4_mag_q;
      s5_neg_q <= s4_neg_q;
      s5_eov_q <= s4_eov_q;
    end
  end

  // stage 6: limb products with |x|
  logic [PA_W-1:0]  s6_pa0_q, s6_pa1_q;
  logic [PAH_W-1:0] s6_pa2_q;
  logic [B_W-1:0]   s6_b_q;
  logic             s6_neg_q, s6_eov_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_pa0_q <= PA_W'(s5_n3_q[LIMB_W-1:0]) * PA_W'(s5_mag_q);
      s6_pa1_q <= PA_W'(s5_n3_q[2*LIMB_W-1:LIMB_W]) * PA_W'(s5_mag_q);
      s6_pa2_q <= PAH_W'(s5_n3_q[N3_W-1:2*LIMB_W]) * PAH_W'(s5_mag_q);
      s6_b_q   <= s5_b_q;
      s6_neg_q <= s5_neg_q;
      s6_eov_q <= s5_eov_q;
    end
  end

  // stage 7: dividend 8A + B (half-LSB rounding) and divisor 2B
  logic [NUM_W-1:0] s7_num_d, s7_num_q;
  logic [DEN_W-1:0] s7_den_q;
  logic             s7_neg_q, s7_eov_q;

  assign s7_num_d = (NUM_W'(s6_pa2_q) << (2 * LIMB_W + A_SH))
                  + (NUM_W'(s6_pa1_q) << (LIMB_W + A_SH))
                  + (NUM_W'(s6_pa0_q) << A_SH)
                  + NUM_W'(s6_b_q);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_num_q <= s7_num_d;
      s7_den_q <= {s6_b_q, 1'b0};
      s7_neg_q <= s6_neg_q;
      s7_eov_q <= s6_eov_q;
    end
  end

  // saturation: quotient of one or more clamps, remainder cleared
  logic             sat;
  logic [NUM_W-1:0] s8_rem_q;
  logic [DEN_W-1:0] s8_den_q;
  div_side_t        s8_side_d, s8_side_q;

  always_comb begin
    sat           = s7_num_q >= (NUM_W'(s7_den_q) << FRAC_W);
    s8_side_d.quo = sat ? ONE_Q14 : '0;
    s8_side_d.neg = s7_neg_q;
    s8_side_d.eov = s7_eov_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SAT]) begin
      s8_rem_q  <= sat ? '0 : s7_num_q;
      s8_den_q  <= s7_den_q;
      s8_side_q <= s8_side_d;
    end
  end

  // restoring divider, bits 13 down to 1
  logic [NUM_W-1:0] rem_w  [0:DIV_STAGES];
  logic [DEN_W-1:0] den_w  [0:DIV_STAGES];
  div_side_t        side_w [0:DIV_STAGES];

  assign rem_w[0]  = s8_rem_q;
  assign den_w[0]  = s8_den_q;
  assign side_w[0] = s8_side_q;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int KB = FRAC_W - 1 - j;
    tra_div_stage #(
      .K (KB)
    ) u_div_stage (
      .clk_i  (clk_i),
      .en_i   (en[ST_SAT+1+j]),
      .rem_i  (rem_w[j][DEN_W+KB:0]),
      .den_i  (den_w[j]),
      .side_i (side_w[j]),
      .rem_o  (rem_w[j+1]),
      .den_o  (den_w[j+1]),
      .side_o (side_w[j+1])
    );
  end

  // last quotient bit and sign into the output register
  logic [DEN_W:0]   rem_last;
  logic [DEN_W+1:0] fin_diff;
  logic [QUO_W-1:0] fin_quo;
  logic [ACT_W-1:0] fin_mag, act_d, act_q;
  logic             eov_q;

  always_comb begin
    rem_last = rem_w[DIV_STAGES][DEN_W:0];
    fin_diff = {1'b0, rem_last} - {2'b00, den_w[DIV_STAGES]};
    fin_quo  = side_w[DIV_STAGES].quo | {{(QUO_W-1){1'b0}}, ~fin_diff[DEN_W+1]};
    fin_mag  = ACT_W'(fin_quo);
    act_d    = side_w[DIV_STAGES].neg ? -fin_mag : fin_mag;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      act_q <= act_d;
      eov_q <= side_w[DIV_STAGES].eov;
    end
  end

  assign out_o.valid             = v_q[ST_OUT];
  assign out_o.activation        = act_q;
  assign out_o.end_of_vector_out = eov_q;

endmodule

[src/tra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_checker: port-level checks of the tanh rational approximation
// Range of the activation, output hold under stall, and input readiness.
// ----------------------------------------------------------------------------
module tra_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [tra_pkg::ACT_W-1:0] activation_i,
  input logic                             end_of_vector_out_i
);
  import tra_pkg::*;

  localparam logic signed [ACT_W-1:0] ACT_MAX = ACT_W'(ONE_Q14);
  localparam logic signed [ACT_W-1:0] ACT_MIN = -ACT_MAX;

  // activation stays within plus or minus one
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (activation_i >= ACT_MIN && activation_i <= ACT_MAX))
    else $error("activation outside plus or minus one");

  // a stalled result holds until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(activation_i) && $stable(end_of_vector_out_i)))
    else $error("stalled result changed before transfer");

  // a free or draining output register lets a new sample in
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while the output can move");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind tanh_rational_approximation tra_checker u_tra_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .activation_i        (out_o.activation),
  .end_of_vector_out_i (out_o.end_of_vector_out)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Pade [7/6] tanh block
// Streams Q3.12 samples through the block with random gaps and stalls on both
// sides, predicts each Q1.14 activation with exact 128-bit integer arithmetic
// and compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tra_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 200;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                eov;
    bit                  drain_first;
  } sample_item_t;

  typedef struct {
    logic [ACT_W-1:0] activation;
    logic             eov;
  } act_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tra_in_if  in_if ();
  tra_out_if out_if ();

  tanh_rational_approximation u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sample_item_t sample_queue[$];
  act_result_t  activation_queue[$];

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  samples_sent  = 0;
  int  results_seen  = 0;
  int  send_gap      = 0;
  int  recv_wait     = 0;
  int  hold_count    = 0;
  bit  hold_done     = 1'b0;
  logic in_taken     = 1'b0;
  logic out_taken    = 1'b0;

  // known values on every input from time zero
  initial begin
    in_if.valid         = 1'b0;
    in_if.sample        = '0;
    in_if.end_of_vector = 1'b0;
    out_if.ready        = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // exact Pade [7/6] quotient in Q1.14, rounded half away from zero, clamped
  function automatic logic [ACT_W-1:0] pade_tanh_q14(input logic [SAMPLE_W-1:0] s);
    logic [127:0] mag;
    logic [127:0] sq;
    logic [127:0] unit;
    logic [127:0] num_poly;
    logic [127:0] den_poly;
    logic [127:0] quo;
    logic [ACT_W-1:0] m;
    mag  = s[SAMPLE_W-1] ? (128'd65536 - 128'(s)) : 128'(s);
    sq   = mag * mag;
    unit = 128'd1 << 24;
    num_poly = ((sq + 128'd378 * unit) * sq + 128'd17325 * unit * unit) * sq
               + 128'd135135 * unit * unit * unit;
    num_poly = num_poly * mag;
    den_poly = ((128'd28 * sq + 128'd3150 * unit) * sq + 128'd62370 * unit * unit) * sq
               + 128'd135135 * unit * unit * unit;
    quo = ((num_poly << 3) + den_poly) / (den_poly << 1);
    if (quo >= 128'd16384) quo = 128'd16384;
    m = quo[ACT_W-1:0];
    return s[SAMPLE_W-1] ? (ACT_W'(0) - m) : m;
  endfunction

  // windows with no idling on either side
  function automatic bit calm_window(input int n);
    return (n >= 100 && n < 160) || (n >= 400 && n < 440);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    act_result_t want;
    act_result_t got;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        want.activation = pade_tanh_q14(in_if.sample);
        want.eov        = in_if.end_of_vector;
        activation_queue.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got.activation = out_if.activation;
        got.eov        = out_if.end_of_vector_out;
        results_seen++;
        if (activation_queue.size() == 0) begin
          $display("%0t: unexpected output, expected none, actual act %0d eov %0b",
                   $time, $signed(got.activation), got.eov);
          error_count++;
        end else begin
          want = activation_queue.pop_front();
          if (got.activation !== want.activation) begin
            $display("%0t: wrong activation, expected %0d actual %0d",
                     $time, $signed(want.activation), $signed(got.activation));
            error_count++;
          end
          if (got.eov !== want.eov) begin
            $display("%0t: wrong end_of_vector_out, expected %0b actual %0b",
                     $time, want.eov, got.eov);
            error_count++;
          end
        end
      end
    end
  end

  // driver: offers pending samples with random gaps after each transfer
  always @(negedge clk_i or negedge rst_ni) begin : driver
    sample_item_t item;
    logic offer;
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.sample        <= '0;
      in_if.end_of_vector <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_taken) begin
        offer = 1'b0;
        samples_sent++;
        send_gap = calm_window(samples_sent) ? 0 : $urandom_range(0, 4);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0 &&
                     !(sample_queue[0].drain_first && activation_queue.size() != 0)) begin
          item = sample_queue.pop_front();
          in_if.sample        <= item.sample;
          in_if.end_of_vector <= item.eov;
          offer = 1'b1;
        end
      end
      in_if.valid <= offer;
    end
  end

  // receiver: random stall after each transfer, one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait  = 0;
      hold_count = 0;
    end else begin
      if (out_taken)
        recv_wait = calm_window(results_seen) ? 0 : $urandom_range(0, 4);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_sample(input logic [SAMPLE_W-1:0] s, input logic eov, input bit drain);
    sample_item_t item;
    item.sample      = s;
    item.eov         = eov;
    item.drain_first = drain;
    sample_queue.push_back(item);
  endtask

  // stimulus and end of run
  initial begin : stimulus
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] mag;
    logic eov;
    int kind;

    // zero, unit steps, range ends, x = +-1, near the saturation knee, tiny values
    add_sample(16'sd0,      1'b0, 1'b0);
    add_sample(16'sd1,      1'b0, 1'b0);
    add_sample(-16'sd1,     1'b1, 1'b0);
    add_sample(16'sd32767,  1'b0, 1'b0);
    add_sample(-16'sd32768, 1'b1, 1'b0);
    add_sample(16'sd4096,   1'b0, 1'b0);
    add_sample(-16'sd4096,  1'b0, 1'b0);
    add_sample(16'sd20300,  1'b0, 1'b0);
    add_sample(16'sd20357,  1'b1, 1'b0);
    add_sample(16'sd20358,  1'b0, 1'b0);
    add_sample(-16'sd20357, 1'b0, 1'b0);
    add_sample(-16'sd20358, 1'b1, 1'b0);
    add_sample(16'sd20400,  1'b0, 1'b0);
    add_sample(16'sd16384,  1'b0, 1'b0);
    add_sample(-16'sd16384, 1'b0, 1'b0);
    add_sample(16'sd2,      1'b1, 1'b0);
    add_sample(16'sd8192,   1'b0, 1'b0);
    add_sample(16'sd12288,  1'b0, 1'b0);
    add_sample(-16'sd12288, 1'b1, 1'b0);
    add_sample(16'sd100,    1'b0, 1'b0);
    add_sample(-16'sd7,     1'b1, 1'b0);

    // random part: full range, small magnitudes and the knee region
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0, 1: begin
          s = SAMPLE_W'($urandom());
        end
        2: begin
          mag = SAMPLE_W'($urandom_range(0, 4095));
          s   = $urandom_range(0, 1) ? (SAMPLE_W'(0) - mag) : mag;
        end
        default: begin
          mag = SAMPLE_W'($urandom_range(18000, 22000));
          s   = $urandom_range(0, 1) ? (SAMPLE_W'(0) - mag) : mag;
        end
      endcase
      eov = ($urandom_range(0, 7) == 0);
      add_sample(s, eov, (i == 0) || (i == 350));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all samples accepted, then all results back, then a short tail
    while (sample_queue.size() != 0 || in_if.valid) @(posedge clk_i);
    while (activation_queue.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
